### hdl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants of the component copy provenance tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

	localparam int NUM_REGS  = 64;
	localparam int REG_W     = $clog2(NUM_REGS);
	localparam int IDX_W     = 12;
	localparam int RINSTR_W  = IDX_W + 1;
	localparam int CNT_W     = 7;
	localparam int NCOMP     = 4;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	// operation classes
	localparam logic [2:0] OP_ARITH = 3'd0;
	localparam logic [2:0] OP_TEX   = 3'd1;
	localparam logic [2:0] OP_MOV   = 3'd2;
	localparam logic [2:0] OP_CMOV  = 3'd3;
	localparam logic [2:0] OP_CMP   = 3'd4;

	// value kinds
	localparam logic [1:0] KIND_ARITH = 2'd0;
	localparam logic [1:0] KIND_TEX   = 2'd1;
	localparam logic [1:0] KIND_COPY  = 2'd2;
	localparam logic [1:0] KIND_CMP   = 2'd3;

	// swizzle modes
	localparam logic [1:0] SWZ_LANES = 2'd1;
	localparam logic [1:0] SWZ_BCAST = 2'd2;

	typedef struct packed {
		logic signed [RINSTR_W-1:0] instr;
		logic [REG_W-1:0]           rnum;
		logic [1:0]                 comp;
	} root_t;

	localparam int ROOT_W = $bits(root_t);

	typedef struct packed {
		logic [REG_W-1:0]      dreg;
		logic [1:0]            kind;
		logic [IDX_W-1:0]      idx;
		logic [NCOMP-1:0]      mask;
		root_t [NCOMP-1:0]     roots;
	} emit_item_t;

	function automatic logic [1:0] kind_of(input logic [2:0] op);
		logic [1:0] k;
		case (op)
			OP_TEX:  k = KIND_TEX;
			OP_MOV:  k = KIND_COPY;
			OP_CMOV: k = KIND_COPY;
			OP_CMP:  k = KIND_CMP;
			default: k = KIND_ARITH;
		endcase
		return k;
	endfunction

	// initial contents of a table entry
	function automatic root_t init_root(input logic [REG_W-1:0] r, input logic [1:0] c);
		root_t v;
		v.instr = '1;
		v.rnum  = r;
		v.comp  = c;
		return v;
	endfunction

endpackage

`default_nettype wire

### hdl/ctp_ram.sv
// ----------------------------------------------------------------------------
// ctp_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/ctp_table.sv
// ----------------------------------------------------------------------------
// ctp_table
// Provenance table: one root RAM per component, per-entry valid bits and
// forwarding of the most recent write to a read issued in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_table (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// read issue at request accept
	input  wire logic                            rd_en,
	input  wire logic [ctp_pkg::REG_W-1:0]       rd_row,
	// resolution against the registered read data
	input  wire logic [ctp_pkg::REG_W-1:0]       src_row,
	input  wire logic                            src_init,
	output      ctp_pkg::root_t [ctp_pkg::NCOMP-1:0] src_roots,
	// update when the held request retires
	input  wire logic                            step,
	input  wire logic                            clear,
	input  wire logic                            wr_en,
	input  wire logic [ctp_pkg::REG_W-1:0]       wr_row,
	input  wire logic [ctp_pkg::NCOMP-1:0]       wr_mask,
	input  wire ctp_pkg::root_t [ctp_pkg::NCOMP-1:0] wr_roots
);
	import ctp_pkg::*;

	logic [NUM_REGS-1:0][NCOMP-1:0] valid_q;
	logic                           rec_valid_q;
	logic [REG_W-1:0]               rec_row_q;
	logic [NCOMP-1:0]               rec_mask_q;
	root_t [NCOMP-1:0]              rec_roots_q;
	logic [NCOMP-1:0][ROOT_W-1:0]   rd_data;

	for (genvar c = 0; c < NCOMP; c++) begin : g_comp
		ctp_ram #(
			.WIDTH(ROOT_W),
			.DEPTH(NUM_REGS)
		) u_ram (
			.clk  (clk),
			.we   (wr_en & step & wr_mask[c]),
			.waddr(wr_row),
			.wdata(wr_roots[c]),
			.re   (rd_en),
			.raddr(rd_row),
			.rdata(rd_data[c])
		);
	end

	always_comb begin
		for (int c = 0; c < NCOMP; c++) begin
			if (src_init) begin
				src_roots[c] = init_root(src_row, 2'(c));
			end else if (rec_valid_q && rec_row_q == src_row && rec_mask_q[c]) begin
				// RAM read raced the last write: take the written value
				src_roots[c] = rec_roots_q[c];
			end else if (valid_q[src_row][c]) begin
				src_roots[c] = rd_data[c];
			end else begin
				src_roots[c] = init_root(src_row, 2'(c));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rec_valid_q <= 1'b0;
		end else if (step) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				if (wr_en && wr_row == REG_W'(r)) begin
					valid_q[r] <= (clear ? '0 : valid_q[r]) | wr_mask;
				end else if (clear) begin
					valid_q[r] <= '0;
				end
			end
			rec_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rec_row_q   <= wr_row;
			rec_mask_q  <= wr_mask;
			rec_roots_q <= wr_roots;
		end
	end

endmodule

`default_nettype wire

### hdl/ctp_emit.sv
// ----------------------------------------------------------------------------
// ctp_emit
// Output stage: holds one instruction's results and sends its written
// components from x to w, one per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_emit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire ctp_pkg::emit_item_t               item,
	output      logic                              ready,
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// component, register_written, value_kind, defining_instruction,
	// root instr, root reg, root comp, written_mask (from bit 0)
	output      logic [ctp_pkg::OUT_DATA_W-1:0]    m_tdata,
	output      logic                              m_tlast
);
	import ctp_pkg::*;

	emit_item_t       item_q;
	logic [NCOMP-1:0] rem_q;
	logic [1:0]       cur;
	logic [NCOMP-1:0] cur_bit;
	root_t            r;

	always_comb begin
		cur = 2'd3;
		if (rem_q[0]) begin
			cur = 2'd0;
		end else if (rem_q[1]) begin
			cur = 2'd1;
		end else if (rem_q[2]) begin
			cur = 2'd2;
		end
		cur_bit = NCOMP'(1) << cur;
		r       = item_q.roots[cur];
	end

	assign m_tvalid = |rem_q;
	assign m_tlast  = (rem_q & ~cur_bit) == '0;
	assign ready    = !m_tvalid || (m_tready && m_tlast);
	assign m_tdata  = {1'b0, item_q.mask, r.comp, r.rnum, r.instr, item_q.idx,
		item_q.kind, item_q.dreg, cur};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= item.mask;
		end else if (m_tvalid && m_tready) begin
			rem_q <= rem_q & ~cur_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

endmodule

`default_nettype wire

### hdl/component_copy_provenance_tracker.sv
// ----------------------------------------------------------------------------
// component_copy_provenance_tracker
// Per-register, per-component provenance of temporary register values.
// ----------------------------------------------------------------------------
// Accepts one decoded instruction per cycle while the output stage can take
// its results. The source row is read from the provenance RAMs in the accept
// cycle; roots are resolved and the table is written when the instruction
// retires from the input register, and a write from the previous instruction
// is forwarded to the following read. Each instruction that writes a tracked
// temporary yields one result per written component (one to four), sent one
// per cycle from the output register while m_tready is high. Table state is
// qualified by valid bits, so reset and a new program take effect at once
// with no clearing pass.
`default_nettype none

module component_copy_provenance_tracker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ctp_pkg::CNT_W-1:0]      cfg_wdata,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	// new_program, op_class, writes_dest, dest_is_temp, dest_reg, dest_mask,
	// src_is_temp, src_reg, swizzle select, swizzle_lanes (from bit 0)
	input  wire logic [ctp_pkg::IN_DATA_W-1:0]  s_tdata,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	// component, register_written, value_kind, defining_instruction,
	// root instr, root reg, root comp, written_mask (from bit 0)
	output      logic [ctp_pkg::OUT_DATA_W-1:0] m_tdata,
	output      logic                           m_tlast
);
	import ctp_pkg::*;

	logic [CNT_W-1:0] reg_count_q;
	logic [IDX_W-1:0] icount_q;

	logic             valid_s1;
	logic             newp_s1;
	logic [2:0]       op_s1;
	logic             wdest_s1;
	logic             dtemp_s1;
	logic [7:0]       dreg_s1;
	logic [3:0]       dmask_s1;
	logic             stemp_s1;
	logic [7:0]       sreg_s1;
	logic [1:0]       swz_s1;
	logic [7:0]       lanes_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             accept;
	logic             in_newp;
	logic [IDX_W-1:0] in_idx;
	logic [CNT_W-1:0] rc;
	logic             has_write;
	logic             copy;
	logic [NCOMP-1:0] eff_mask;
	logic             fire;
	logic             emit_ready;
	root_t [NCOMP-1:0] src_roots;
	root_t [NCOMP-1:0] new_roots;
	emit_item_t       item;

	assign accept  = s_tvalid && s_tready;
	assign in_newp = s_tdata[0];
	assign in_idx  = in_newp ? '0 : icount_q;

	always_comb begin
		rc = reg_count_q;
		if (reg_count_q == '0) begin
			rc = CNT_W'(1);
		end else if (reg_count_q > CNT_W'(NUM_REGS)) begin
			rc = CNT_W'(NUM_REGS);
		end
	end

	assign has_write = wdest_s1 && dtemp_s1 && ({1'b0, dreg_s1} < {2'b0, rc});
	assign copy      = (op_s1 == OP_MOV) && stemp_s1 && ({1'b0, sreg_s1} < {2'b0, rc});
	assign eff_mask  = (dmask_s1 == '0) ? '1 : dmask_s1;
	assign fire      = valid_s1 && (!has_write || emit_ready);
	assign s_tready  = !valid_s1 || fire;

	always_comb begin
		logic [1:0] sc;
		for (int c = 0; c < NCOMP; c++) begin
			case (swz_s1)
				SWZ_BCAST: sc = lanes_s1[1:0];
				SWZ_LANES: sc = lanes_s1[2*c +: 2];
				default:   sc = 2'(c);
			endcase
			if (copy) begin
				new_roots[c] = src_roots[sc];
			end else begin
				new_roots[c].instr = {1'b0, idx_s1};
				new_roots[c].rnum  = dreg_s1[REG_W-1:0];
				new_roots[c].comp  = 2'(c);
			end
		end
	end

	always_comb begin
		item.dreg  = dreg_s1[REG_W-1:0];
		item.kind  = kind_of(op_s1);
		item.idx   = idx_s1;
		item.mask  = eff_mask;
		item.roots = new_roots;
	end

	ctp_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_row   (s_tdata[19 +: REG_W]),
		.src_row  (sreg_s1[REG_W-1:0]),
		.src_init (newp_s1),
		.src_roots(src_roots),
		.step     (fire),
		.clear    (newp_s1),
		.wr_en    (has_write),
		.wr_row   (dreg_s1[REG_W-1:0]),
		.wr_mask  (eff_mask),
		.wr_roots (new_roots)
	);

	ctp_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && has_write),
		.item    (item),
		.ready   (emit_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_count_q <= CNT_W'(NUM_REGS);
			icount_q    <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				reg_count_q <= cfg_wdata;
			end
			if (accept) begin
				icount_q <= in_idx + IDX_W'(1);
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			newp_s1  <= s_tdata[0];
			op_s1    <= s_tdata[3:1];
			wdest_s1 <= s_tdata[4];
			dtemp_s1 <= s_tdata[5];
			dreg_s1  <= s_tdata[13:6];
			dmask_s1 <= s_tdata[17:14];
			stemp_s1 <= s_tdata[18];
			sreg_s1  <= s_tdata[26:19];
			swz_s1   <= s_tdata[28:27];
			lanes_s1 <= s_tdata[36:29];
			idx_s1   <= in_idx;
		end
	end

endmodule

`default_nettype wire
